// File: sv/atg_pkg.sv
// Shared constants, codes and the arctangent table of the tilt and gyro integrator.
package atg_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF    = 48;
  localparam int ANGLE_ITER_DEF  = 16;

  localparam int TILT_W      = 15;
  localparam int TS_W        = 16;
  localparam int ATAN_IDX_W  = 5;
  localparam int ATAN_W      = 23;
  localparam int ANGLE_LIMIT = 11520;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TIME_STEP = 1'b0;
  localparam logic [TS_W-1:0] TIME_STEP_RESET = 16'd6554;

  // atan(2^-i) in degrees, 16 fraction bits; zero past the end of the table
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/atg_in_if.sv
// Input channel: one IMU sample beat.
interface atg_in_if #(
  parameter int SAMPLE_BITS = atg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic signed [SAMPLE_BITS-1:0] rate_x;
  logic signed [SAMPLE_BITS-1:0] rate_y;
  logic signed [SAMPLE_BITS-1:0] rate_z;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

// File: sv/atg_out_if.sv
// Result channel: one attitude result beat.
interface atg_out_if #(
  parameter int SUM_BITS = atg_pkg::SUM_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [atg_pkg::TILT_W-1:0]  tilt_roll;
  logic signed [atg_pkg::TILT_W-1:0]  tilt_pitch;
  logic signed [atg_pkg::TILT_W-1:0]  tilt_yaw;
  logic signed [SUM_BITS-1:0]         gyro_roll;
  logic signed [SUM_BITS-1:0]         gyro_pitch;
  logic signed [SUM_BITS-1:0]         gyro_yaw;

  modport source (output valid, tilt_roll, tilt_pitch, tilt_yaw,
                  gyro_roll, gyro_pitch, gyro_yaw, input ready);
  modport sink   (input valid, tilt_roll, tilt_pitch, tilt_yaw,
                  gyro_roll, gyro_pitch, gyro_yaw, output ready);
endinterface

// File: sv/accel_tilt_gyro_integrate.sv
// Top level: gyro integration and accelerometer tilt by shared multiplier, root and CORDIC.
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | accel_x/y/z, rate_x/y/z
//   out_ch  | out | valid/ready        | tilt_roll/pitch/yaw, gyro_roll/pitch/yaw
//   cfg_*   | in  | APB, pready high   | time_step at byte address 0
//
// A sample runs through three multiply/accumulate steps, then per tilt angle the squaring of
// both axes under the root, a load, a root of SAMPLE_BITS + 8 bits, a load, one CORDIC step per
// cycle and a final scale; the result register is then loaded, and the next beat is taken
// in the idle state.
// in_ch.ready is high only while the sequencer is idle; the result register holds its beat
// while out_ch.ready is low, and the sequencer waits in its last state until the register
// frees. Synchronous active-low reset clears the accumulators and restores time_step.
module accel_tilt_gyro_integrate #(
  parameter int SAMPLE_BITS      = atg_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS         = atg_pkg::SUM_BITS_DEF,
  parameter int ANGLE_ITERATIONS = atg_pkg::ANGLE_ITER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  atg_in_if.sink                         in_ch,
  atg_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [atg_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [atg_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [atg_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int TS_W    = atg_pkg::TS_W;
  localparam int TILT_W  = atg_pkg::TILT_W;
  localparam int MUL_W   = ((SAMPLE_BITS > TS_W) ? SAMPLE_BITS : TS_W) + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SW      = ((SUM_BITS > PROD_W) ? SUM_BITS : PROD_W) + 2;
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int RAD_W   = SQ_W + 16;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int RCNT_W  = $clog2(ROOT_W + 1);
  localparam int CW      = SAMPLE_BITS + 11;
  localparam int ZW      = 26;
  localparam int ICNT_W  = $clog2(ANGLE_ITERATIONS + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_GMUL  = 11'b00000000010,
    S_GADD  = 11'b00000000100,
    S_SQP   = 11'b00000001000,
    S_SQQ   = 11'b00000010000,
    S_RINIT = 11'b00000100000,
    S_ROOT  = 11'b00001000000,
    S_CINIT = 11'b00010000000,
    S_CORD  = 11'b00100000000,
    S_ANGLE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TS_W-1:0]               ts_r;
  logic signed [SAMPLE_BITS-1:0] ax_r, ay_r, az_r;
  logic signed [SAMPLE_BITS-1:0] rate_r [3];
  logic signed [SUM_BITS-1:0]    acc_r [3];
  logic [1:0]                    k_r;
  logic [1:0]                    t_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic [SQ_W-1:0]               sq_r;
  logic [RAD_W-1:0]              rad_r;
  logic [REM_W-1:0]              rem_r;
  logic [ROOT_W-1:0]             root_r;
  logic [RCNT_W-1:0]             rcnt_r;
  logic signed [CW-1:0]          x_r, y_r;
  logic signed [ZW-1:0]          z_r;
  logic [ICNT_W-1:0]             icnt_r;
  logic                          zero_r;
  logic signed [TILT_W-1:0]      tilt_r [3];
  logic                          out_valid_r;

  // Config port: time_step write and read back
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[atg_pkg::CFG_ADDR_W-1] == atg_pkg::REG_TIME_STEP);
  assign cfg_prdata = (cfg_paddr[atg_pkg::CFG_ADDR_W-1] == atg_pkg::REG_TIME_STEP) ?
                      {{(atg_pkg::CFG_DATA_W-TS_W){1'b0}}, ts_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= atg_pkg::TIME_STEP_RESET;
    end else if (cfg_wr) begin
      ts_r <= cfg_pwdata[TS_W-1:0];
    end
  end

  // Tilt operands: numerator and the two axes under the root
  logic signed [SAMPLE_BITS-1:0] n_sel, p_sel, q_sel;
  always_comb begin
    case (t_r)
      2'd0:    begin n_sel = ay_r; p_sel = ax_r; end
      2'd1:    begin n_sel = ax_r; p_sel = ay_r; end
      default: begin n_sel = ax_r; p_sel = ax_r; end
    endcase
    q_sel = az_r;
  end

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  always_comb begin
    case (state_r)
      S_GMUL: begin
        mul_a = MUL_W'(rate_r[k_r]);
        mul_b = signed'({{(MUL_W-TS_W){1'b0}}, ts_r});
      end
      S_SQP: begin
        mul_a = MUL_W'(p_sel);
        mul_b = MUL_W'(p_sel);
      end
      S_SQQ: begin
        mul_a = MUL_W'(q_sel);
        mul_b = MUL_W'(q_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Saturating accumulate
  localparam logic signed [SW-1:0] SUM_MAX =
    signed'({{(SW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] SUM_MIN = -SUM_MAX - SW'(1);
  logic signed [SW-1:0]       sum_w;
  logic signed [SUM_BITS-1:0] sum_sat;
  assign sum_w = SW'(acc_r[k_r]) + SW'(prod_r);
  always_comb begin
    if (sum_w > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_BITS-1:0];
    end else if (sum_w < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_BITS-1:0];
    end else begin
      sum_sat = sum_w[SUM_BITS-1:0];
    end
  end

  // Root step: bring down two radicand bits, try to subtract
  logic [REM_W+1:0] rem_ext, trial;
  logic             rbit;
  assign rem_ext = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign rbit    = (rem_ext >= trial);

  // CORDIC step
  logic signed [CW-1:0]  dx, dy;
  logic signed [ZW-1:0]  tz;
  assign dx = y_r >>> icnt_r;
  assign dy = x_r >>> icnt_r;
  assign tz = signed'(ZW'(atg_pkg::atan_q16(atg_pkg::ATAN_IDX_W'(icnt_r))));

  // Final scale and clamp
  localparam logic signed [ZW-1:0] LIM_Z = ZW'(atg_pkg::ANGLE_LIMIT);
  logic signed [ZW-1:0]     zr;
  logic signed [TILT_W-1:0] ang, ang_out;
  assign zr = (z_r + ZW'(256)) >>> 9;
  always_comb begin
    if (zero_r) begin
      ang = '0;
    end else if (zr > LIM_Z) begin
      ang = TILT_W'(atg_pkg::ANGLE_LIMIT);
    end else if (zr < -LIM_Z) begin
      ang = -TILT_W'(atg_pkg::ANGLE_LIMIT);
    end else begin
      ang = zr[TILT_W-1:0];
    end
    ang_out = (t_r == 2'd1) ? ang : -ang;
  end

  logic out_free;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_GMUL;
      S_GMUL:  state_nxt = S_GADD;
      S_GADD:  state_nxt = (k_r == 2'd2) ? S_SQP : S_GMUL;
      S_SQP:   state_nxt = S_SQQ;
      S_SQQ:   state_nxt = S_RINIT;
      S_RINIT: state_nxt = S_ROOT;
      S_ROOT:  if (rcnt_r == RCNT_W'(ROOT_W - 1)) state_nxt = S_CINIT;
      S_CINIT: state_nxt = (ANGLE_ITERATIONS > 0) ? S_CORD : S_ANGLE;
      S_CORD:  if (icnt_r == ICNT_W'(ANGLE_ITERATIONS - 1)) state_nxt = S_ANGLE;
      S_ANGLE: state_nxt = (t_r == 2'd2) ? S_DONE : S_SQP;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
      k_r      <= '0;
      t_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ax_r      <= in_ch.accel_x;
            ay_r      <= in_ch.accel_y;
            az_r      <= in_ch.accel_z;
            rate_r[0] <= in_ch.rate_x;
            rate_r[1] <= in_ch.rate_y;
            rate_r[2] <= in_ch.rate_z;
            k_r       <= '0;
            t_r       <= '0;
          end
        end
        S_GMUL: prod_r <= mul_p;
        S_GADD: begin
          acc_r[k_r] <= sum_sat;
          k_r        <= k_r + 2'd1;
        end
        S_SQP: prod_r <= mul_p;
        S_SQQ: begin
          sq_r   <= prod_r[SQ_W-1:0];
          prod_r <= mul_p;
        end
        S_RINIT: begin
          rad_r  <= {sq_r + prod_r[SQ_W-1:0], 16'b0};
          rem_r  <= '0;
          root_r <= '0;
          rcnt_r <= '0;
        end
        S_ROOT: begin
          rem_r  <= rbit ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
          root_r <= {root_r[ROOT_W-2:0], rbit};
          rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
          rcnt_r <= rcnt_r + RCNT_W'(1);
        end
        S_CINIT: begin
          x_r    <= signed'(CW'(root_r));
          y_r    <= CW'(n_sel) <<< 8;
          z_r    <= '0;
          icnt_r <= '0;
          zero_r <= (root_r == '0) && (n_sel == '0);
        end
        S_CORD: begin
          if (!y_r[CW-1]) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + tz;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - tz;
          end
          icnt_r <= icnt_r + ICNT_W'(1);
        end
        S_ANGLE: begin
          tilt_r[t_r] <= ang_out;
          t_r         <= t_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Result register: load on finish, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r       <= 1'b1;
      out_ch.tilt_roll  <= tilt_r[0];
      out_ch.tilt_pitch <= tilt_r[1];
      out_ch.tilt_yaw   <= tilt_r[2];
      out_ch.gyro_roll  <= acc_r[0];
      out_ch.gyro_pitch <= acc_r[1];
      out_ch.gyro_yaw   <= acc_r[2];
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid_r;

endmodule

// File: tb/accel_tilt_gyro_integrate_tb.sv
// Testbench for the tilt and gyro integrator: directed and random IMU samples checked per beat.
module accel_tilt_gyro_integrate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = atg_pkg::SAMPLE_BITS_DEF;
  localparam int SW = atg_pkg::SUM_BITS_DEF;
  localparam int NITER = atg_pkg::ANGLE_ITER_DEF;
  localparam int TILT_W = atg_pkg::TILT_W;
  localparam int TS_W = atg_pkg::TS_W;
  localparam int CFG_ADDR_W = atg_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = atg_pkg::CFG_DATA_W;
  localparam int ANGLE_LIMIT = atg_pkg::ANGLE_LIMIT;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TIME_STEP =
    CFG_ADDR_W'(4 * atg_pkg::REG_TIME_STEP);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = CFG_ADDR_W'(4);
  localparam logic signed [SB-1:0] MAXS = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] MINS = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0] ax, ay, az, rx, ry, rz;
  } imu_sample_t;

  typedef struct packed {
    logic [TILT_W-1:0] roll, pitch, yaw;
    logic [SW-1:0]     g_roll, g_pitch, g_yaw;
  } attitude_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  atg_in_if  in_ch();
  atg_out_if out_ch();

  accel_tilt_gyro_integrate u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [TS_W-1:0]    step_q16 = atg_pkg::TIME_STEP_RESET;
  logic signed [63:0] angle_acc [3] = '{0, 0, 0};
  attitude_t          pending_results [$];
  int                 mismatch_count = 0;
  bit                 hold_receiver = 1'b0;
  bit                 stimulus_done = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.rate_x = '0;  in_ch.rate_y = '0;  in_ch.rate_z = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    forever #4 clk = ~clk;
  end

  // atan(2^-i) in degrees, 16 fraction bits
  const longint atan_steps [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // atan2(n, sqrt(p^2 + q^2)) in 1/128 degree
  function automatic longint tilt_angle(longint n, longint p, longint q);
    longint unsigned pa, qa;
    longint x, y, z, dx, dy, r;
    pa = (p < 0) ? -p : p;
    qa = (q < 0) ? -q : q;
    x = longint'(int_root((pa * pa + qa * qa) << 16));
    y = n * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < NITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_steps[i];
      end else begin
        x -= dx; y += dy; z -= atan_steps[i];
      end
    end
    r = (z + 256) >>> 9;
    if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
    if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
    return r;
  endfunction

  // advance the accumulators and work out the attitude beat for one sample
  function automatic attitude_t predict_attitude(imu_sample_t s);
    attitude_t a;
    longint maxv, minv, p;
    longint rates [3];
    maxv = (64'sd1 <<< (SW - 1)) - 1;
    minv = -maxv - 1;
    rates = '{longint'(s.rx), longint'(s.ry), longint'(s.rz)};
    for (int k = 0; k < 3; k++) begin
      p = rates[k] * longint'({1'b0, step_q16});
      if (p > 0 && angle_acc[k] > maxv - p) angle_acc[k] = maxv;
      else if (p < 0 && angle_acc[k] < minv - p) angle_acc[k] = minv;
      else angle_acc[k] = angle_acc[k] + p;
    end
    a.roll    = TILT_W'(-tilt_angle(s.ay, s.ax, s.az));
    a.pitch   = TILT_W'(tilt_angle(s.ax, s.ay, s.az));
    a.yaw     = TILT_W'(-tilt_angle(s.ax, s.ax, s.az));
    a.g_roll  = SW'(angle_acc[0]);
    a.g_pitch = SW'(angle_acc[1]);
    a.g_yaw   = SW'(angle_acc[2]);
    return a;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // send one sample beat; valid stays high when the next beat follows at once
  task automatic send_sample(imu_sample_t s);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= s.ax; in_ch.accel_y <= s.ay; in_ch.accel_z <= s.az;
    in_ch.rate_x  <= s.rx; in_ch.rate_y  <= s.ry; in_ch.rate_z  <= s.rz;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_attitude(s));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // wait until every result is back and the sequencer has gone quiet
  task automatic wait_idle();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_TIME_STEP) step_q16 = data[TS_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic check_time_step_readback();
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0; cfg_paddr <= ADDR_TIME_STEP;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[TS_W-1:0] !== step_q16)
      report_mismatch("time_step readback", cfg_prdata[TS_W-1:0], step_q16);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] rand_field();
    case ($urandom_range(0, 9))
      0: return MINS;
      1: return MAXS;
      2: return '0;
      3: return SB'(int'($urandom_range(0, 15)) - 8);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    s.ax = rand_field(); s.ay = rand_field(); s.az = rand_field();
    s.rx = rand_field(); s.ry = rand_field(); s.rz = rand_field();
    // tilt special cases: zero vector and vertical vector
    case ($urandom_range(0, 19))
      0: begin s.ax = '0; s.ay = '0; s.az = '0; end
      1: begin s.ax = '0; s.az = '0; end
      2: begin s.ay = '0; s.az = '0; end
      default: ;
    endcase
    return s;
  endfunction

  // extremes, zero vector, vertical axes and the reset time step
  task automatic test_directed();
    imu_sample_t s [$];
    s.push_back('{ax: 0, ay: 0, az: 0, rx: 0, ry: 0, rz: 0});
    s.push_back('{ax: MAXS, ay: MAXS, az: MAXS, rx: MAXS, ry: MAXS, rz: MAXS});
    s.push_back('{ax: MINS, ay: MINS, az: MINS, rx: MINS, ry: MINS, rz: MINS});
    s.push_back('{ax: 0, ay: MAXS, az: 0, rx: 1, ry: -1, rz: 0});
    s.push_back('{ax: 0, ay: MINS, az: 0, rx: -1, ry: 1, rz: 0});
    s.push_back('{ax: MAXS, ay: 0, az: 0, rx: 0, ry: 0, rz: 1});
    s.push_back('{ax: MINS, ay: 0, az: 0, rx: 0, ry: 0, rz: -1});
    s.push_back('{ax: 0, ay: 0, az: MAXS, rx: MAXS, ry: MINS, rz: 0});
    s.push_back('{ax: 0, ay: 0, az: MINS, rx: MINS, ry: MAXS, rz: 0});
    s.push_back('{ax: 1, ay: -1, az: 0, rx: 0, ry: 0, rz: 0});
    s.push_back('{ax: MAXS, ay: MINS, az: 1, rx: 100, ry: -100, rz: 7});
    s.push_back('{ax: -1, ay: -1, az: -1, rx: -1, ry: -1, rz: -1});
    foreach (s[i]) send_sample(s[i]);
    wait_idle();
  endtask

  // time step extremes, ignored register, readback
  task automatic test_config();
    logic [TS_W-1:0] steps [4] = '{16'd0, 16'hFFFF, 16'd1, 16'd32768};
    check_time_step_readback();
    foreach (steps[i]) begin
      apb_write(ADDR_TIME_STEP, CFG_DATA_W'(steps[i]));
      check_time_step_readback();
      repeat (6) send_sample(rand_sample());
      wait_idle();
    end
    apb_write(ADDR_UNUSED, 32'h0000_1234);
    check_time_step_readback();
    repeat (4) send_sample(rand_sample());
    wait_idle();
  endtask

  // hold the receiver off while samples keep coming
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      repeat (1500) @(posedge clk);
      repeat (10) send_sample(rand_sample());
    join_any
    hold_receiver = 1'b0;
    wait fork;
    wait_idle();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 5; phase++) begin
      apb_write(ADDR_TIME_STEP, (phase == 4) ? 32'hFFFF : CFG_DATA_W'($urandom));
      repeat (215) send_sample(rand_sample());
      wait_idle();
    end
  endtask

  // receiver: random stalls, a few long
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ch.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    attitude_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.tilt_roll !== w.roll)
          report_mismatch("tilt_roll", $signed(out_ch.tilt_roll), $signed(w.roll));
        if (out_ch.tilt_pitch !== w.pitch)
          report_mismatch("tilt_pitch", $signed(out_ch.tilt_pitch), $signed(w.pitch));
        if (out_ch.tilt_yaw !== w.yaw)
          report_mismatch("tilt_yaw", $signed(out_ch.tilt_yaw), $signed(w.yaw));
        if (out_ch.gyro_roll !== w.g_roll)
          report_mismatch("gyro_roll", $signed(out_ch.gyro_roll), $signed(w.g_roll));
        if (out_ch.gyro_pitch !== w.g_pitch)
          report_mismatch("gyro_pitch", $signed(out_ch.gyro_pitch), $signed(w.g_pitch));
        if (out_ch.gyro_yaw !== w.g_yaw)
          report_mismatch("gyro_yaw", $signed(out_ch.gyro_yaw), $signed(w.g_yaw));
      end
    end
  end

  // watchdog: end the run when no beat moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stimulus_done)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config();
    test_backpressure();
    test_random();
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 0, pending_results.size());
    stimulus_done = 1'b1;
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/atg_pkg.sv
sv/atg_in_if.sv
sv/atg_out_if.sv
sv/accel_tilt_gyro_integrate.sv
tb/accel_tilt_gyro_integrate_tb.sv
